FILE: hdl/ibp_pkg.sv
// ----------------------------------------------------------------------------
// ibp_pkg
// Shared constants, register codes and types of the interior bound push block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibp_pkg;

  // Default element format: signed Q16.16.
  localparam int DEF_VALUE_WIDTH   = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Push and gap factors are unsigned Q0.16.
  localparam int FACTOR_WIDTH = 16;
  localparam int FACTOR_SHIFT = 16;

  localparam logic [FACTOR_WIDTH-1:0] PUSH_FACTOR_RESET = 16'd655;
  localparam logic [FACTOR_WIDTH-1:0] GAP_FACTOR_RESET  = 16'd655;

  // Configuration port geometry: registers at byte addresses 0 and 4.
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int REG_ADDR_LSB   = 2;

  // Register index codes.
  localparam logic REG_PUSH_FACTOR = 1'b0;
  localparam logic REG_GAP_FACTOR  = 1'b1;

  // Per-element flags carried down the pipeline.
  typedef struct packed {
    logic has_lower;
    logic has_upper;
    logic gap_neg;
  } ibp_flags_t;

endpackage

`default_nettype wire

FILE: hdl/ibp_if.sv
// ----------------------------------------------------------------------------
// ibp_if
// Request channels of the interior bound push block: element in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibp_in_if #(
  parameter int VALUE_WIDTH = ibp_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] current_value;
  logic signed [VALUE_WIDTH-1:0] lower_bound;
  logic signed [VALUE_WIDTH-1:0] upper_bound;
  logic                          has_lower;
  logic                          has_upper;

  modport source (
    output valid, current_value, lower_bound, upper_bound, has_lower, has_upper,
    input  ready
  );
  modport sink (
    input  valid, current_value, lower_bound, upper_bound, has_lower, has_upper,
    output ready
  );
endinterface

interface ibp_out_if #(
  parameter int VALUE_WIDTH = ibp_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] projected_value;

  modport source (output valid, projected_value, input ready);
  modport sink   (input valid, projected_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/ibp_cfg.sv
// ----------------------------------------------------------------------------
// ibp_cfg
// APB-style register file holding the push factor and the gap factor.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_cfg (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [ibp_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  wire logic [ibp_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic      [ibp_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                        pready,
  output logic      [ibp_pkg::FACTOR_WIDTH-1:0]       push_factor,
  output logic      [ibp_pkg::FACTOR_WIDTH-1:0]       gap_factor
);

  logic [ibp_pkg::FACTOR_WIDTH-1:0] push_factor_r, push_factor_nxt;
  logic [ibp_pkg::FACTOR_WIDTH-1:0] gap_factor_r, gap_factor_nxt;
  logic                             wr_en;
  logic                             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ibp_pkg::REG_ADDR_LSB];

  // Register write decode.
  always_comb begin
    push_factor_nxt = push_factor_r;
    gap_factor_nxt  = gap_factor_r;
    if (wr_en) begin
      unique case (reg_idx)
        ibp_pkg::REG_PUSH_FACTOR: push_factor_nxt = pwdata[ibp_pkg::FACTOR_WIDTH-1:0];
        ibp_pkg::REG_GAP_FACTOR:  gap_factor_nxt  = pwdata[ibp_pkg::FACTOR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_factor_r <= ibp_pkg::PUSH_FACTOR_RESET;
      gap_factor_r  <= ibp_pkg::GAP_FACTOR_RESET;
    end else begin
      push_factor_r <= push_factor_nxt;
      gap_factor_r  <= gap_factor_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ibp_pkg::REG_PUSH_FACTOR: prdata[ibp_pkg::FACTOR_WIDTH-1:0] = push_factor_r;
      ibp_pkg::REG_GAP_FACTOR:  prdata[ibp_pkg::FACTOR_WIDTH-1:0] = gap_factor_r;
      default: ;
    endcase
  end

  assign push_factor = push_factor_r;
  assign gap_factor  = gap_factor_r;

endmodule

`default_nettype wire

FILE: hdl/ibp_front.sv
// ----------------------------------------------------------------------------
// ibp_front
// First two pipeline stages: bound magnitudes and gap, then the scaled pushes.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_front #(
  parameter int VALUE_WIDTH   = ibp_pkg::DEF_VALUE_WIDTH,
  parameter int FRACTION_BITS = ibp_pkg::DEF_FRACTION_BITS,
  parameter int MAG_W         = (VALUE_WIDTH > FRACTION_BITS) ? VALUE_WIDTH
                                                              : FRACTION_BITS + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [ibp_pkg::FACTOR_WIDTH-1:0] push_factor,
  input  wire logic [ibp_pkg::FACTOR_WIDTH-1:0] gap_factor,
  // Upstream request
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_value,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_lower,
  input  wire logic signed [VALUE_WIDTH-1:0]    in_upper,
  input  wire logic                             in_has_lower,
  input  wire logic                             in_has_upper,
  // Downstream request
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output logic signed [VALUE_WIDTH-1:0]         dn_value,
  output logic signed [VALUE_WIDTH-1:0]         dn_lower,
  output logic signed [VALUE_WIDTH-1:0]         dn_upper,
  output ibp_pkg::ibp_flags_t                   dn_flags,
  output logic [MAG_W-1:0]                      dn_push_lo,
  output logic [MAG_W-1:0]                      dn_push_hi,
  output logic [MAG_W-1:0]                      dn_gap_term
);

  localparam int EXT_W  = MAG_W + 1;
  localparam int PROD_W = MAG_W + ibp_pkg::FACTOR_WIDTH;
  localparam logic [MAG_W-1:0] ONE = {{(MAG_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  // Stage one registers
  logic                          s1_vld_r, s1_vld_nxt;
  logic signed [VALUE_WIDTH-1:0] s1_value_r, s1_lower_r, s1_upper_r;
  ibp_pkg::ibp_flags_t           s1_flags_r;
  logic [MAG_W-1:0]              s1_mag_lo_r, s1_mag_hi_r, s1_gap_mag_r;
  // Stage two registers
  logic                          s2_vld_r, s2_vld_nxt;
  logic signed [VALUE_WIDTH-1:0] s2_value_r, s2_lower_r, s2_upper_r;
  ibp_pkg::ibp_flags_t           s2_flags_r;
  logic [MAG_W-1:0]              s2_push_lo_r, s2_push_hi_r, s2_gap_term_r;

  logic                          s1_adv, s2_adv;
  logic signed [EXT_W-1:0]       lo_ext, hi_ext, lo_abs, hi_abs, gap_diff, gap_abs;
  logic [MAG_W-1:0]              mag_lo, mag_hi;
  logic [PROD_W-1:0]             prod_lo, prod_hi, prod_gap;
  ibp_pkg::ibp_flags_t           flags_in;

  // Per-stage flow control: a stage moves when it is empty or the next one moves.
  assign s2_adv   = !s2_vld_r || dn_ready;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  // Stage one: magnitudes clamped to at least one, and the signed bound gap.
  always_comb begin
    lo_ext   = $signed({{(EXT_W-VALUE_WIDTH){in_lower[VALUE_WIDTH-1]}}, in_lower});
    hi_ext   = $signed({{(EXT_W-VALUE_WIDTH){in_upper[VALUE_WIDTH-1]}}, in_upper});
    lo_abs   = lo_ext[EXT_W-1] ? -lo_ext : lo_ext;
    hi_abs   = hi_ext[EXT_W-1] ? -hi_ext : hi_ext;
    mag_lo   = (lo_abs[MAG_W-1:0] > ONE) ? lo_abs[MAG_W-1:0] : ONE;
    mag_hi   = (hi_abs[MAG_W-1:0] > ONE) ? hi_abs[MAG_W-1:0] : ONE;
    gap_diff = hi_ext - lo_ext;
    gap_abs  = gap_diff[EXT_W-1] ? -gap_diff : gap_diff;
    flags_in.has_lower = in_has_lower;
    flags_in.has_upper = in_has_upper;
    flags_in.gap_neg   = gap_diff[EXT_W-1];
  end

  // Stage two: scale by the Q0.16 factors, keeping the floor of the product.
  always_comb begin
    prod_lo  = PROD_W'(s1_mag_lo_r)  * PROD_W'(push_factor);
    prod_hi  = PROD_W'(s1_mag_hi_r)  * PROD_W'(push_factor);
    prod_gap = PROD_W'(s1_gap_mag_r) * PROD_W'(gap_factor);
  end

  // Valid bits.
  always_comb begin
    s1_vld_nxt = s1_adv ? in_valid : s1_vld_r;
    s2_vld_nxt = s2_adv ? s1_vld_r : s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_value_r   <= in_value;
      s1_lower_r   <= in_lower;
      s1_upper_r   <= in_upper;
      s1_flags_r   <= flags_in;
      s1_mag_lo_r  <= mag_lo;
      s1_mag_hi_r  <= mag_hi;
      s1_gap_mag_r <= gap_abs[MAG_W-1:0];
    end
    if (s2_adv) begin
      s2_value_r    <= s1_value_r;
      s2_lower_r    <= s1_lower_r;
      s2_upper_r    <= s1_upper_r;
      s2_flags_r    <= s1_flags_r;
      s2_push_lo_r  <= prod_lo[PROD_W-1:ibp_pkg::FACTOR_SHIFT];
      s2_push_hi_r  <= prod_hi[PROD_W-1:ibp_pkg::FACTOR_SHIFT];
      s2_gap_term_r <= prod_gap[PROD_W-1:ibp_pkg::FACTOR_SHIFT];
    end
  end

  assign dn_valid    = s2_vld_r;
  assign dn_value    = s2_value_r;
  assign dn_lower    = s2_lower_r;
  assign dn_upper    = s2_upper_r;
  assign dn_flags    = s2_flags_r;
  assign dn_push_lo  = s2_push_lo_r;
  assign dn_push_hi  = s2_push_hi_r;
  assign dn_gap_term = s2_gap_term_r;

endmodule

`default_nettype wire

FILE: hdl/ibp_back.sv
// ----------------------------------------------------------------------------
// ibp_back
// Last two pipeline stages: push targets, then compare, select and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_back #(
  parameter int VALUE_WIDTH = ibp_pkg::DEF_VALUE_WIDTH,
  parameter int MAG_W       = ibp_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Upstream request
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] up_value,
  input  wire logic signed [VALUE_WIDTH-1:0] up_lower,
  input  wire logic signed [VALUE_WIDTH-1:0] up_upper,
  input  wire ibp_pkg::ibp_flags_t           up_flags,
  input  wire logic [MAG_W-1:0]              up_push_lo,
  input  wire logic [MAG_W-1:0]              up_push_hi,
  input  wire logic [MAG_W-1:0]              up_gap_term,
  // Result request
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0]      out_value
);

  localparam int SUM_W = MAG_W + 2;
  localparam logic signed [SUM_W-1:0] VAL_MAX =
    $signed({{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] VAL_MIN =
    $signed({{(SUM_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});

  // Stage three registers
  logic                          s3_vld_r, s3_vld_nxt;
  logic signed [VALUE_WIDTH-1:0] s3_value_r;
  ibp_pkg::ibp_flags_t           s3_flags_r;
  logic signed [SUM_W-1:0]       s3_tgt_lo_r, s3_tgt_hi_r;
  // Output stage registers
  logic                          s4_vld_r, s4_vld_nxt;
  logic signed [VALUE_WIDTH-1:0] s4_value_r;

  logic                          s3_adv, s4_adv;
  logic                          both, inward;
  logic [MAG_W-1:0]              marg_lo, marg_hi, min_lo, min_hi;
  logic signed [SUM_W-1:0]       lo_ext, hi_ext, mlo_ext, mhi_ext, tgt_lo, tgt_hi;
  logic signed [SUM_W-1:0]       x_ext, pick;
  logic                          take_lo, take_hi;
  logic signed [VALUE_WIDTH-1:0] sat_value;

  // Per-stage flow control.
  assign s4_adv   = !s4_vld_r || out_ready;
  assign s3_adv   = !s3_vld_r || s4_adv;
  assign up_ready = s3_adv;

  // Stage three: margins and exact push targets on each side.
  // With both bounds and an inverted gap the margin is the gap term and the
  // targets move outward; otherwise the targets move inward.
  always_comb begin
    both    = up_flags.has_lower & up_flags.has_upper;
    inward  = !(both && up_flags.gap_neg);
    min_lo  = (up_push_lo < up_gap_term) ? up_push_lo : up_gap_term;
    min_hi  = (up_push_hi < up_gap_term) ? up_push_hi : up_gap_term;
    marg_lo = !both ? up_push_lo : (up_flags.gap_neg ? up_gap_term : min_lo);
    marg_hi = !both ? up_push_hi : (up_flags.gap_neg ? up_gap_term : min_hi);
    lo_ext  = $signed({{(SUM_W-VALUE_WIDTH){up_lower[VALUE_WIDTH-1]}}, up_lower});
    hi_ext  = $signed({{(SUM_W-VALUE_WIDTH){up_upper[VALUE_WIDTH-1]}}, up_upper});
    mlo_ext = $signed({2'b00, marg_lo});
    mhi_ext = $signed({2'b00, marg_hi});
    tgt_lo  = inward ? (lo_ext + mlo_ext) : (lo_ext - mlo_ext);
    tgt_hi  = inward ? (hi_ext - mhi_ext) : (hi_ext + mhi_ext);
  end

  // Output stage: the lower side has priority, then saturate the chosen value.
  always_comb begin
    x_ext   = $signed({{(SUM_W-VALUE_WIDTH){s3_value_r[VALUE_WIDTH-1]}}, s3_value_r});
    take_lo = s3_flags_r.has_lower && (x_ext < s3_tgt_lo_r);
    take_hi = s3_flags_r.has_upper && (x_ext > s3_tgt_hi_r);
    priority if (take_lo) begin
      pick = s3_tgt_lo_r;
    end else if (take_hi) begin
      pick = s3_tgt_hi_r;
    end else begin
      pick = x_ext;
    end
    priority if (pick > VAL_MAX) begin
      sat_value = VAL_MAX[VALUE_WIDTH-1:0];
    end else if (pick < VAL_MIN) begin
      sat_value = VAL_MIN[VALUE_WIDTH-1:0];
    end else begin
      sat_value = pick[VALUE_WIDTH-1:0];
    end
  end

  // Valid bits.
  always_comb begin
    s3_vld_nxt = s3_adv ? up_valid : s3_vld_r;
    s4_vld_nxt = s4_adv ? s3_vld_r : s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_value_r  <= up_value;
      s3_flags_r  <= up_flags;
      s3_tgt_lo_r <= tgt_lo;
      s3_tgt_hi_r <= tgt_hi;
    end
    if (s4_adv) begin
      s4_value_r <= sat_value;
    end
  end

  assign out_valid = s4_vld_r;
  assign out_value = s4_value_r;

endmodule

`default_nettype wire

FILE: hdl/interior_bound_projection_core.sv
// ----------------------------------------------------------------------------
// interior_bound_projection_core
// Pushes one vector element per request inside its bounds (outward if they are inverted).
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one element per request: the value, its lower and upper
//   bounds (signed fixed point) and one flag per bound saying it applies.
//   out_chan returns the pushed value, saturated to the element width.
//   The APB-style port holds the push factor (address 0) and the gap factor
//   (address 4), both unsigned Q0.16; write them only while no request is
//   in flight.
// Timing:
//   Four register stages: magnitudes and gap, the three factor multipliers,
//   push targets, then compare, select and saturate. One request is taken
//   every cycle while out_chan does not stall.
// Reset and stalls:
//   rst_n clears every stage's valid bit and loads both factors with 655.
//   Each stage advances when it is empty or the next one advances, so a stall
//   on out_chan fills the bubbles first and then holds every stage intact.
// ----------------------------------------------------------------------------
`default_nettype none

module interior_bound_projection_core #(
  parameter int VALUE_WIDTH   = ibp_pkg::DEF_VALUE_WIDTH,
  parameter int FRACTION_BITS = ibp_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  ibp_in_if.sink                                  in_chan,
  ibp_out_if.source                               out_chan,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ibp_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  wire logic [ibp_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic      [ibp_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                    pready
);

  localparam int MAG_W = (VALUE_WIDTH > FRACTION_BITS) ? VALUE_WIDTH : FRACTION_BITS + 1;

  logic [ibp_pkg::FACTOR_WIDTH-1:0] push_factor, gap_factor;
  logic                             mid_valid, mid_ready;
  logic signed [VALUE_WIDTH-1:0]    mid_value, mid_lower, mid_upper;
  ibp_pkg::ibp_flags_t              mid_flags;
  logic [MAG_W-1:0]                 mid_push_lo, mid_push_hi, mid_gap_term;

  // Factor registers.
  ibp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .push_factor (push_factor),
    .gap_factor  (gap_factor)
  );

  // Magnitudes and scaled pushes.
  ibp_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .MAG_W         (MAG_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_factor  (push_factor),
    .gap_factor   (gap_factor),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_value     (in_chan.current_value),
    .in_lower     (in_chan.lower_bound),
    .in_upper     (in_chan.upper_bound),
    .in_has_lower (in_chan.has_lower),
    .in_has_upper (in_chan.has_upper),
    .dn_valid     (mid_valid),
    .dn_ready     (mid_ready),
    .dn_value     (mid_value),
    .dn_lower     (mid_lower),
    .dn_upper     (mid_upper),
    .dn_flags     (mid_flags),
    .dn_push_lo   (mid_push_lo),
    .dn_push_hi   (mid_push_hi),
    .dn_gap_term  (mid_gap_term)
  );

  // Targets, selection and saturation.
  ibp_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAG_W       (MAG_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (mid_valid),
    .up_ready    (mid_ready),
    .up_value    (mid_value),
    .up_lower    (mid_lower),
    .up_upper    (mid_upper),
    .up_flags    (mid_flags),
    .up_push_lo  (mid_push_lo),
    .up_push_hi  (mid_push_hi),
    .up_gap_term (mid_gap_term),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_value   (out_chan.projected_value)
  );

endmodule

`default_nettype wire
